### hw/rtl/ray_triangle_intersection_macros.svh
// Assertion macros for the checker file of the ray/triangle block.
// Depends on nothing; included by rti_checker.sv.
`ifndef RAY_TRIANGLE_INTERSECTION_MACROS_SVH
`define RAY_TRIANGLE_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define RTI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define RTI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rti_pkg.sv
// Package for the ray/triangle intersection block: default widths and
// configuration register indexes. Depends on nothing.
package rti_pkg;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int CSR_IDX_WIDTH   = 3;
   localparam int THR_WIDTH       = 32;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_Z      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_X         = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_Y         = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_Z         = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DET_THRESHOLD = 3'd6;
endpackage

### hw/rtl/ray_triangle_intersection.sv
// Pipelined fixed-point ray/triangle intersection test (Moller-Trumbore).
// Depends on rti_pkg for default widths and register indexes.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | req_tdata: 9 vertex coordinates
//  rsp     | out       | rsp_tvalid/tready    | rsp_tdata: hit, distance, u, v
//  csr     | in        | csr_valid/csr_ready  | csr_addr, csr_data
//
// One triangle may enter every cycle unless a stalled result holds the pipeline full;
// each passes the edge, product, cross, dot product, decision, divider and output stages.
// Synchronous reset: valid bits and origin clear, direction becomes +z, threshold 1.
// Every stage holds its item while the stage after it is full and stalled,
// so empty stages still take new transactions while a result waits.
module ray_triangle_intersection #(
   parameter int COORD_WIDTH = rti_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = rti_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, t_hit, bary_u, bary_v from the lowest bit up
   output logic [((1+COORD_WIDTH+2*(FRAC_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rti_pkg::CSR_IDX_WIDTH-1:0] csr_addr,
   input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_data
);
   import rti_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int CW    = W + 1;
   localparam int PW    = 2*CW + 1;
   localparam int PL    = CW + 1;
   localparam int MLW   = CW + PL + 1;
   localparam int MHW   = 2*CW;
   localparam int DPW   = CW + PW;
   localparam int DW    = DPW + 2;
   localparam int NSTEP = (W > F) ? W : F + 1;
   localparam int RW    = DW + NSTEP + F;
   localparam int NPIPE = NSTEP + 8;
   localparam int ODW   = ((1+W+2*(F+1)+7)/8)*8;
   localparam int DIV0  = 6;
   localparam int LIMW  = THR_WIDTH + 2*F;

   // Ray registers.
   logic signed [W-1:0]         org_ff [3];
   logic signed [W-1:0]         dir_ff [3];
   logic [THR_WIDTH-1:0]        thr_ff;
   logic signed [CW-1:0]        dext [3];

   // Pipeline control.
   logic [NPIPE-1:0]            vld_ff;
   logic [NPIPE-1:0]            ld;

   // Edge stage, product stage and cross stage.
   logic signed [CW-1:0]        e1_ff [3][3];
   logic signed [CW-1:0]        e2_ff [3][3];
   logic signed [CW-1:0]        s_ff  [3][3];
   logic signed [CW-1:0]        e1_in [3];
   logic signed [CW-1:0]        e2_in [3];
   logic signed [CW-1:0]        s_in  [3];
   logic signed [MHW-1:0]       pm_ff [6];
   logic signed [MHW-1:0]       qm_ff [6];
   logic signed [PW-1:0]        p_ff  [3];
   logic signed [PW-1:0]        q_ff  [3];

   // Dot product stages.
   logic signed [CW-1:0]        xo [4][3];
   logic signed [PW-1:0]        yo [4][3];
   logic signed [MLW-1:0]       mlo_ff [4][3];
   logic signed [MHW-1:0]       mhi_ff [4][3];
   logic signed [DPW-1:0]       prod_ff [4][3];
   logic signed [DW-1:0]        dot_ff [4];

   // Decision stage and divider lanes; entry 0 is loaded by the decision stage.
   logic [RW-1:0]               rem_ff  [NSTEP+1][3];
   logic [NSTEP-1:0]            quo_ff  [NSTEP+1][3];
   logic [DW-1:0]               den_ff  [NSTEP+1];
   logic                        miss_ff [NSTEP+1];
   logic                        tneg_ff [NSTEP+1];
   logic                        ovf_ff  [NSTEP+1];

   logic [DW-1:0]               mdet, mru, mrv, mrt;
   logic signed [DW-1:0]        sru, srv, srt;
   logic                        dneg, miss_in, ovf_in;
   logic [DW:0]                 uv_sum;
   logic [LIMW-1:0]             lim;

   logic [ODW-1:0]              rsp_ff;
   logic [ODW-1:0]              rsp_in;
   logic [NSTEP-1:0]            tlim, tsat;
   logic [W-1:0]                tdist;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
         dir_ff[2] <= W'(1) << F;
         thr_ff    <= THR_WIDTH'(1);
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_ORIGIN_X:      org_ff[0] <= csr_data[W-1:0];
            CSR_ORIGIN_Y:      org_ff[1] <= csr_data[W-1:0];
            CSR_ORIGIN_Z:      org_ff[2] <= csr_data[W-1:0];
            CSR_DIR_X:         dir_ff[0] <= csr_data[W-1:0];
            CSR_DIR_Y:         dir_ff[1] <= csr_data[W-1:0];
            CSR_DIR_Z:         dir_ff[2] <= csr_data[W-1:0];
            CSR_DET_THRESHOLD: thr_ff    <= csr_data[THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dext[i] = {dir_ff[i][W-1], dir_ff[i]};
      end
   end

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      ld[NPIPE-1] = !vld_ff[NPIPE-1] || rsp_tready;
      for (int i = NPIPE-2; i >= 0; i--) begin
         ld[i] = !vld_ff[i] || ld[i+1];
      end
   end

   assign req_tready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NPIPE; i++) begin
            if (ld[i]) begin
               vld_ff[i] <= (i == 0) ? req_tvalid : vld_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   // Stage 0: edges and origin offset, all exact in W+1 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = CW'($signed(req_tdata[(3+i)*W +: W])) - CW'($signed(req_tdata[i*W +: W]));
         e2_in[i] = CW'($signed(req_tdata[(6+i)*W +: W])) - CW'($signed(req_tdata[i*W +: W]));
         s_in[i]  = CW'(org_ff[i]) - CW'($signed(req_tdata[i*W +: W]));
      end
   end

   always_ff @(posedge clock) begin
      // Stage 0 loads from the port, stages 1 and 2 carry the edges along.
      if (ld[0]) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[0][i] <= e1_in[i];
            e2_ff[0][i] <= e2_in[i];
            s_ff[0][i]  <= s_in[i];
         end
      end
      for (int k = 1; k < 3; k++) begin
         if (ld[k]) begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[k][i] <= e1_ff[k-1][i];
               e2_ff[k][i] <= e2_ff[k-1][i];
               s_ff[k][i]  <= s_ff[k-1][i];
            end
         end
      end
   end

   // Stage 1: the twelve products of p = dir x e2 and q = s x e1.
   always_ff @(posedge clock) begin
      if (ld[1]) begin
         pm_ff[0] <= dext[1] * e2_ff[0][2];
         pm_ff[1] <= dext[2] * e2_ff[0][1];
         pm_ff[2] <= dext[2] * e2_ff[0][0];
         pm_ff[3] <= dext[0] * e2_ff[0][2];
         pm_ff[4] <= dext[0] * e2_ff[0][1];
         pm_ff[5] <= dext[1] * e2_ff[0][0];
         qm_ff[0] <= s_ff[0][1] * e1_ff[0][2];
         qm_ff[1] <= s_ff[0][2] * e1_ff[0][1];
         qm_ff[2] <= s_ff[0][2] * e1_ff[0][0];
         qm_ff[3] <= s_ff[0][0] * e1_ff[0][2];
         qm_ff[4] <= s_ff[0][0] * e1_ff[0][1];
         qm_ff[5] <= s_ff[0][1] * e1_ff[0][0];
      end
   end

   // Stage 2: cross product differences.
   always_ff @(posedge clock) begin
      if (ld[2]) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= PW'(pm_ff[2*i]) - PW'(pm_ff[2*i+1]);
            q_ff[i] <= PW'(qm_ff[2*i]) - PW'(qm_ff[2*i+1]);
         end
      end
   end

   // Operands of the four dot products: det, ru, rv and rt.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xo[0][i] = e1_ff[2][i];
         yo[0][i] = p_ff[i];
         xo[1][i] = s_ff[2][i];
         yo[1][i] = p_ff[i];
         xo[2][i] = dext[i];
         yo[2][i] = q_ff[i];
         xo[3][i] = e2_ff[2][i];
         yo[3][i] = q_ff[i];
      end
   end

   // Stage 3: each wide product is split into a low unsigned and a high signed half.
   always_ff @(posedge clock) begin
      if (ld[3]) begin
         for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
               mlo_ff[k][i] <= xo[k][i] * $signed({1'b0, yo[k][i][PL-1:0]});
               mhi_ff[k][i] <= xo[k][i] * $signed(yo[k][i][PW-1:PL]);
            end
         end
      end
   end

   // Stage 4: recombine the halves.
   always_ff @(posedge clock) begin
      if (ld[4]) begin
         for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[k][i] <= $signed({mhi_ff[k][i], {PL{1'b0}}}) + DPW'(mlo_ff[k][i]);
            end
         end
      end
   end

   // Stage 5: sums of the dot products.
   always_ff @(posedge clock) begin
      if (ld[5]) begin
         for (int k = 0; k < 4; k++) begin
            dot_ff[k] <= DW'(prod_ff[k][0]) + DW'(prod_ff[k][1]) + DW'(prod_ff[k][2]);
         end
      end
   end

   // Stage 6: sign mirror, threshold and inside tests, distance overflow check.
   always_comb begin
      dneg   = dot_ff[0][DW-1];
      mdet   = dneg ? DW'(-dot_ff[0]) : DW'(dot_ff[0]);
      sru    = dneg ? -dot_ff[1] : dot_ff[1];
      srv    = dneg ? -dot_ff[2] : dot_ff[2];
      srt    = dneg ? -dot_ff[3] : dot_ff[3];
      mru    = DW'(sru);
      mrv    = DW'(srv);
      mrt    = srt[DW-1] ? DW'(-srt) : DW'(srt);
      lim    = {thr_ff, {(2*F){1'b0}}};
      uv_sum = {1'b0, mru} + {1'b0, mrv};
      miss_in = (mdet <= DW'(lim)) || sru[DW-1] || (mru > mdet) || srv[DW-1]
                || (uv_sum > {1'b0, mdet});
      ovf_in = ({{(W+F){1'b0}}, mrt} >= {mdet, {(W+F){1'b0}}} >> F);
   end

   always_ff @(posedge clock) begin
      if (ld[DIV0]) begin
         rem_ff[0][0] <= RW'(mru) << F;
         rem_ff[0][1] <= RW'(mrv) << F;
         rem_ff[0][2] <= RW'(mrt) << F;
         for (int l = 0; l < 3; l++) begin
            quo_ff[0][l] <= '0;
         end
         den_ff[0]  <= mdet;
         miss_ff[0] <= miss_in;
         tneg_ff[0] <= srt[DW-1];
         ovf_ff[0]  <= ovf_in;
      end
   end

   // Divider lanes: one quotient bit per stage, most significant bit first.
   for (genvar j = 1; j <= NSTEP; j++) begin : g_div
      localparam int KB = NSTEP - j;
      logic [RW-1:0] dsh;
      logic [RW-1:0] rem_in [3];
      logic [NSTEP-1:0] quo_in [3];

      always_comb begin
         dsh = RW'(den_ff[j-1]) << KB;
         for (int l = 0; l < 3; l++) begin
            rem_in[l] = rem_ff[j-1][l];
            quo_in[l] = quo_ff[j-1][l];
            if (rem_ff[j-1][l] >= dsh) begin
               rem_in[l]     = rem_ff[j-1][l] - dsh;
               quo_in[l][KB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ld[DIV0+j]) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[j][l] <= rem_in[l];
               quo_ff[j][l] <= quo_in[l];
            end
            den_ff[j]  <= den_ff[j-1];
            miss_ff[j] <= miss_ff[j-1];
            tneg_ff[j] <= tneg_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
         end
      end
   end

   // Output stage: saturate the distance and zero everything on a miss.
   always_comb begin
      tlim  = tneg_ff[NSTEP] ? (NSTEP'(1) << (W-1)) : ((NSTEP'(1) << (W-1)) - NSTEP'(1));
      tsat  = (ovf_ff[NSTEP] || (quo_ff[NSTEP][2] > tlim)) ? tlim : quo_ff[NSTEP][2];
      tdist = tneg_ff[NSTEP] ? W'(-tsat) : W'(tsat);
      rsp_in = '0;
      if (!miss_ff[NSTEP]) begin
         rsp_in[0]                  = 1'b1;
         rsp_in[W:1]                = tdist;
         rsp_in[W+1 +: F+1]         = quo_ff[NSTEP][0][F:0];
         rsp_in[W+F+2 +: F+1]       = quo_ff[NSTEP][1][F:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NPIPE-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = vld_ff[NPIPE-1];
   assign rsp_tdata  = rsp_ff;
endmodule

### hw/rtl/rti_checker.sv
// Port-level checks of the ray/triangle intersection block and their bind.
// Depends on ray_triangle_intersection_macros.svh and rti_pkg.
`include "ray_triangle_intersection_macros.svh"

module rti_checker #(
   parameter int COORD_WIDTH = rti_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = rti_pkg::DEF_FRAC_BITS
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   // hit, t_hit, bary_u, bary_v from the lowest bit up
   input logic [((1+COORD_WIDTH+2*(FRAC_BITS+1)+7)/8)*8-1:0] rsp_tdata
);
   import rti_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int F = FRAC_BITS;

   logic [F+1:0] uv_sum;

   // Barycentric weights of a hit never sum past one.
   assign uv_sum = {1'b0, rsp_tdata[W+1 +: F+1]} + {1'b0, rsp_tdata[W+F+2 +: F+1]};

   // A miss carries no numbers.
   `RTI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0],
      rsp_tdata[W+2*F+2:1] == '0, "miss transaction with nonzero fields")

   `RTI_ASSERT_NOW(a_uv_range, clock, reset, rsp_tvalid && rsp_tdata[0],
      uv_sum <= ((F+2)'(1) << F), "barycentric weights sum above one")

   // A stalled result stays put.
   `RTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result transaction changed")

   // Reset empties the pipeline.
   `RTI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid,
      "result valid right after reset")
endmodule

bind ray_triangle_intersection rti_checker #(
   .COORD_WIDTH(COORD_WIDTH),
   .FRAC_BITS(FRAC_BITS)
) u_rti_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for the ray/triangle intersection block.
// Depends on rti_pkg and ray_triangle_intersection; predicts each result from its own model.
`timescale 1ns / 100ps

module tb_top;
   import rti_pkg::*;

   localparam int CW = DEF_COORD_WIDTH;
   localparam int FB = DEF_FRAC_BITS;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 60;

   typedef logic signed [191:0] wide_t;
   typedef wide_t vec3_t [3];
   typedef logic signed [CW-1:0] coord_t;
   typedef coord_t tri_t [9];
   typedef struct packed {
      logic [FB:0] v;
      logic [FB:0] u;
      logic [CW-1:0] t_hit;
      logic hit;
   } hit_rec_t;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
   logic [287:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // hit, t_hit, bary_u, bary_v from the lowest bit up
   logic [71:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_addr;
   logic [31:0] csr_data;

   // Shadow copy of the ray registers.
   coord_t ray_org [3];
   coord_t ray_dir [3];
   logic [31:0] thr_reg;

   hit_rec_t expected_hits [$];
   int mismatches = 0;
   int unexpected = 0;
   int items_sent = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int csr_writes = 0;
   bit tx_calm = 0;
   bit rx_calm = 0;

   ray_triangle_intersection uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_addr(csr_addr), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #4800000;
      $display("Timeout with %0d results outstanding.", expected_hits.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic vec3_t cross3(vec3_t x, vec3_t y);
      vec3_t r;
      r[0] = x[1] * y[2] - x[2] * y[1];
      r[1] = x[2] * y[0] - x[0] * y[2];
      r[2] = x[0] * y[1] - x[1] * y[0];
      return r;
   endfunction

   function automatic wide_t dot3(vec3_t x, vec3_t y);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
   endfunction

   // Exact Moller-Trumbore test in wide integers against the shadow ray.
   function automatic hit_rec_t predict_hit(tri_t tv);
      vec3_t a, e1, e2, s, d, p, q;
      wide_t det, ru, rv, rt, lim, mag, tlim, w;
      hit_rec_t r;
      bit tneg;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         a[i] = tv[i];
         e1[i] = wide_t'(tv[3+i]) - a[i];
         e2[i] = wide_t'(tv[6+i]) - a[i];
         s[i] = wide_t'(ray_org[i]) - a[i];
         d[i] = ray_dir[i];
      end
      p = cross3(d, e2);
      det = dot3(e1, p);
      lim = '0;
      lim[63:32] = thr_reg;
      if (((det < 0) ? -det : det) <= lim) return r;
      q = cross3(s, e1);
      ru = dot3(s, p);
      rv = dot3(d, q);
      rt = dot3(e2, q);
      // The mirrored test for a negative determinant.
      if (det < 0) begin
         det = -det; ru = -ru; rv = -rv; rt = -rt;
      end
      if (ru < 0 || ru > det || rv < 0 || ru + rv > det) return r;
      tneg = rt < 0;
      mag = ((tneg ? -rt : rt) <<< FB) / det;
      tlim = 1;
      tlim = tlim <<< (CW - 1);
      if (!tneg) tlim = tlim - 1;
      if (mag > tlim) mag = tlim;
      w = tneg ? -mag : mag;
      r.hit = 1'b1;
      r.t_hit = w[CW-1:0];
      w = (ru <<< FB) / det;
      r.u = w[FB:0];
      w = (rv <<< FB) / det;
      r.v = w[FB:0];
      return r;
   endfunction

   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(99);
      if (calm || roll < 60) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic note_mismatch(string what, logic [CW-1:0] exp_val, logic [CW-1:0] act_val);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch in %s at %0t: expected %h, got %h", what, $realtime, exp_val,
                  act_val);
   endtask

   // Compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      hit_rec_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[66:0];
         results_seen++;
         if (got.hit) hits_seen++;
         if (expected_hits.size() == 0) begin
            unexpected++;
            $display("Result with no pending triangle at %0t", $realtime);
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit) note_mismatch("hit", want.hit, got.hit);
            if (got.t_hit !== want.t_hit) note_mismatch("t_hit", want.t_hit, got.t_hit);
            if (got.u !== want.u) note_mismatch("bary_u", want.u, got.u);
            if (got.v !== want.v) note_mismatch("bary_v", want.v, got.v);
         end
      end
   end

   // Result side back-pressure: mostly ready, short and occasional long stalls.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (rx_calm) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap(1'b0);
            rsp_tready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   // One register write; the channel is left idle before the task returns.
   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_ORIGIN_X: ray_org[0] = value;
         CSR_ORIGIN_Y: ray_org[1] = value;
         CSR_ORIGIN_Z: ray_org[2] = value;
         CSR_DIR_X: ray_dir[0] = value;
         CSR_DIR_Y: ray_dir[1] = value;
         CSR_DIR_Z: ray_dir[2] = value;
         CSR_DET_THRESHOLD: thr_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stops sending and waits until the pipeline is empty so the ray can be changed.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      wait (expected_hits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                          coord_t dz, logic [31:0] thr);
      wait_idle();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      write_csr(CSR_DIR_X, dx);
      write_csr(CSR_DIR_Y, dy);
      write_csr(CSR_DIR_Z, dz);
      write_csr(CSR_DET_THRESHOLD, thr);
   endtask

   // Sends one triangle transaction and records its predicted result.
   task automatic send_tri(tri_t tv);
      int gap;
      logic [287:0] word;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      for (int i = 0; i < 9; i++) word[32*i +: 32] = tv[i];
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      expected_hits.push_back(predict_hit(tv));
      items_sent++;
   endtask

   // Triangle with vertices given in whole units.
   task automatic send_units(int ax, int ay, int az, int bx, int by, int bz,
                             int cx, int cy, int cz);
      tri_t tv;
      tv = '{ax <<< FB, ay <<< FB, az <<< FB, bx <<< FB, by <<< FB, bz <<< FB,
             cx <<< FB, cy <<< FB, cz <<< FB};
      send_tri(tv);
   endtask

   function automatic coord_t small_coord(int whole);
      return $signed($urandom_range(2 * (whole << FB))) - (whole << FB);
   endfunction

   task automatic test_directed();
      tri_t tv;
      // Plain hit, mirrored winding, hit behind the origin, clear miss.
      send_units(-1, -1, 5, 2, -1, 5, -1, 2, 5);
      send_units(-1, -1, 5, -1, 2, 5, 2, -1, 5);
      send_units(-1, -1, -5, 2, -1, -5, -1, 2, -5);
      send_units(3, 3, 5, 4, 3, 5, 3, 4, 5);
      // Ray through a vertex and through a point on an edge.
      send_units(0, 0, 5, 2, 0, 5, 0, 2, 5);
      send_units(-2, 0, 5, 0, 0, 5, -2, 2, 5);
      send_units(-1, 0, 5, 1, 0, 5, 0, 2, 5);
      // Collapsed triangle, collinear vertices, triangle parallel to the ray.
      send_units(1, 1, 1, 1, 1, 1, 1, 1, 1);
      send_units(0, 0, 3, 1, 1, 3, 2, 2, 3);
      send_units(0, 0, 5, 1, 0, 6, 0, 0, 7);
      // Extreme coordinate patterns.
      for (int i = 0; i < 9; i++) tv[i] = 32'h7fffffff;
      send_tri(tv);
      for (int i = 0; i < 9; i++) tv[i] = 32'h80000000;
      send_tri(tv);
      for (int i = 0; i < 9; i++) tv[i] = i[0] ? 32'h80000000 : 32'h7fffffff;
      send_tri(tv);
      tv = '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
      send_tri(tv);
   endtask

   task automatic test_ray_extremes();
      // Zero direction: every triangle is degenerate.
      set_ray(0, 0, 0, 0, 0, 0, 0);
      send_units(-1, -1, 5, 2, -1, 5, -1, 2, 5);
      // Largest threshold rejects a normal hit.
      set_ray(0, 0, 0, 0, 0, 1 <<< FB, 32'hffffffff);
      send_units(-1, -1, 5, 2, -1, 5, -1, 2, 5);
      send_units(-30000, -30000, 5, 30000, -30000, 5, -30000, 30000, 5);
      // Tiny direction pushes the distance out of range both ways.
      set_ray(0, 0, 0, 0, 0, 1, 0);
      send_units(-1, -1, 30000, 2, -1, 30000, -1, 2, 30000);
      send_units(-1, -1, -30000, 2, -1, -30000, -1, 2, -30000);
      // Extreme origin and direction values, plus the unused register index.
      set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 0);
      write_csr(CSR_UNUSED, 32'hffffffff);
      send_units(-1, -1, 5, 2, -1, 5, -1, 2, 5);
      for (int i = 0; i < 4; i++) begin
         tri_t tv;
         for (int k = 0; k < 9; k++) tv[k] = $urandom;
         send_tri(tv);
      end
   endtask

   // Random ray, then triangles built mostly around points on that ray, some fully random.
   task automatic test_random_phase(int count, bit full_ray);
      coord_t org [3];
      coord_t dirv [3];
      logic [31:0] thr;
      tri_t tv;
      int roll;
      longint step;
      for (int i = 0; i < 3; i++) begin
         org[i] = full_ray ? coord_t'($urandom) : small_coord(8);
         dirv[i] = full_ray ? coord_t'($urandom) : small_coord(2);
      end
      roll = $urandom_range(3);
      thr = (roll == 0) ? 32'd0 : (roll == 1) ? 32'd1 : (roll == 2) ? $urandom_range(255)
            : $urandom;
      set_ray(org[0], org[1], org[2], dirv[0], dirv[1], dirv[2], thr);
      tx_calm = $urandom_range(3) == 0;
      rx_calm = $urandom_range(3) == 0;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 15) begin
            for (int k = 0; k < 9; k++) tv[k] = $urandom;
         end else begin
            step = $signed($urandom_range(32)) - 8;
            for (int k = 0; k < 9; k++)
               tv[k] = org[k % 3] + coord_t'(step * dirv[k % 3]) + small_coord(4);
         end
         send_tri(tv);
      end
      tx_calm = 0;
      rx_calm = 0;
   endtask

   task automatic test_drain_pause();
      for (int n = 0; n < 20; n++) send_units(-1, -1, n, 2, -1, n, -1, 2, n);
      req_tvalid <= 1'b0;
      wait (expected_hits.size() == 0);
      @(posedge clock);
      for (int n = 0; n < 5; n++) send_units(-2, -1, n, 2, -1, n, -1, 2, n);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_addr = '0;
      csr_data = '0;
      ray_org = '{0, 0, 0};
      ray_dir = '{0, 0, 1 <<< FB};
      thr_reg = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_ray_extremes();
      set_ray(0, 0, 0, 0, 0, 1 <<< FB, 1);
      test_drain_pause();
      for (int ph = 0; ph < 8; ph++) test_random_phase(100, ph == 3 || ph == 6);
      req_tvalid <= 1'b0;

      wait (expected_hits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d triangles over %0d register writes; %0d results checked, %0d hits.",
               items_sent, csr_writes, results_seen, hits_seen);
      $display("Mismatches: %0d, unexpected results: %0d.", mismatches, unexpected);
      if (mismatches == 0 && unexpected == 0 && expected_hits.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
